// ===== hdl/gpg_pkg.sv =====
// Shared types, constants and the 5x7 font ROM for the glyph pixel generator.
// No dependencies.
package gpg_pkg;

   localparam int GlyphBits = 35;                 // 5 columns x 7 rows

   localparam logic [7:0] Advance    = 8'd6;
   localparam logic [7:0] LineLimit  = 8'd122;
   localparam logic [7:0] CaseOffset = 8'd32;
   localparam logic [7:0] LowerA     = 8'd97;
   localparam logic [7:0] LowerZ     = 8'd122;
   localparam logic [7:0] CodeNul    = 8'd0;
   localparam logic [2:0] LastRow    = 3'd6;

   localparam logic KindStart = 1'b0;
   localparam logic KindChar  = 1'b1;

   typedef logic [GlyphBits-1:0] glyph_type;

   // Load command from the text state to the scanner
   typedef struct packed {
      logic        load;
      glyph_type   glyph;
      logic [7:0]  base_x;
      logic [7:0]  base_y;
      logic [15:0] color;
   } scan_load_type;

   // Column 0 in the low bits, row 0 (top) as bit 0 of each column
   function automatic glyph_type pack_cols(input logic [7:0] c0, input logic [7:0] c1,
                                           input logic [7:0] c2, input logic [7:0] c3,
                                           input logic [7:0] c4);
      return {c4[6:0], c3[6:0], c2[6:0], c1[6:0], c0[6:0]};
   endfunction

   // Glyphs exist for A..Z only; everything else is blank
   function automatic glyph_type font_glyph(input logic [7:0] code);
      glyph_type g;
      unique case (code)
         8'h41:   g = pack_cols(8'h7C, 8'h12, 8'h11, 8'h12, 8'h7C);
         8'h42:   g = pack_cols(8'h7F, 8'h49, 8'h49, 8'h49, 8'h36);
         8'h43:   g = pack_cols(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
         8'h44:   g = pack_cols(8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C);
         8'h45:   g = pack_cols(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
         8'h46:   g = pack_cols(8'h7F, 8'h09, 8'h09, 8'h09, 8'h01);
         8'h47:   g = pack_cols(8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A);
         8'h48:   g = pack_cols(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
         8'h49:   g = pack_cols(8'h00, 8'h41, 8'h7F, 8'h41, 8'h00);
         8'h4A:   g = pack_cols(8'h20, 8'h40, 8'h41, 8'h3F, 8'h01);
         8'h4B:   g = pack_cols(8'h7F, 8'h08, 8'h14, 8'h22, 8'h41);
         8'h4C:   g = pack_cols(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
         8'h4D:   g = pack_cols(8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F);
         8'h4E:   g = pack_cols(8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F);
         8'h4F:   g = pack_cols(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
         8'h50:   g = pack_cols(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
         8'h51:   g = pack_cols(8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E);
         8'h52:   g = pack_cols(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
         8'h53:   g = pack_cols(8'h46, 8'h49, 8'h49, 8'h49, 8'h31);
         8'h54:   g = pack_cols(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
         8'h55:   g = pack_cols(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
         8'h56:   g = pack_cols(8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F);
         8'h57:   g = pack_cols(8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F);
         8'h58:   g = pack_cols(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
         8'h59:   g = pack_cols(8'h07, 8'h08, 8'h70, 8'h08, 8'h07);
         8'h5A:   g = pack_cols(8'h61, 8'h51, 8'h49, 8'h45, 8'h43);
         default: g = '0;
      endcase
      return g;
   endfunction

endpackage

// ===== hdl/gpg_if.sv =====
// Valid/ready channel interfaces for text items and pixel results.
// No dependencies.
interface gpg_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  char_code;
   logic [7:0]  start_x;
   logic [7:0]  start_y;
   logic [15:0] text_color;

   modport source (output valid, kind, char_code, start_x, start_y, text_color, input ready);
   modport sink   (input valid, kind, char_code, start_x, start_y, text_color, output ready);
endinterface

interface gpg_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  pixel_x;
   logic [7:0]  pixel_y;
   logic [15:0] pixel_color;
   logic        last;

   modport source (output valid, pixel_x, pixel_y, pixel_color, last, input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_color, last, output ready);
endinterface

// ===== hdl/gpg_text.sv =====
// Text state: cursor, color and stop flag; decodes one item into a scan load.
// Depends on gpg_pkg.
module gpg_text (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  kind,
   input  logic [7:0]            char_code,
   input  logic [7:0]            start_x,
   input  logic [7:0]            start_y,
   input  logic [15:0]           text_color,
   output gpg_pkg::scan_load_type scan_load
);
   import gpg_pkg::*;

   logic [7:0]  cursor_x_ff, cursor_x_in;
   logic [7:0]  cursor_y_ff, cursor_y_in;
   logic [15:0] color_ff, color_in;
   logic        stopped_ff, stopped_in;
   logic [7:0]  folded;
   logic [7:0]  next_x;
   logic        draw;

   always_comb begin
      folded = (char_code >= LowerA && char_code <= LowerZ) ? char_code - CaseOffset
                                                            : char_code;
      next_x = cursor_x_ff + Advance;
      draw   = accept && kind == KindChar && !stopped_ff && char_code != CodeNul;

      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      color_in    = color_ff;
      stopped_in  = stopped_ff;
      if (accept && kind == KindStart) begin
         cursor_x_in = start_x;
         cursor_y_in = start_y;
         color_in    = text_color;
         stopped_in  = 1'b0;
      end else if (accept && !stopped_ff) begin
         if (char_code == CodeNul) begin
            stopped_in = 1'b1;
         end else begin
            cursor_x_in = next_x;
            stopped_in  = next_x > LineLimit;
         end
      end

      // codes outside A..Z and a..z load a blank glyph: no pixels, scanner stays idle
      scan_load.load   = draw;
      scan_load.glyph  = font_glyph(folded);
      scan_load.base_x = cursor_x_ff;
      scan_load.base_y = cursor_y_ff;
      scan_load.color  = color_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff <= '0;
         cursor_y_ff <= '0;
         color_ff    <= '0;
         stopped_ff  <= 1'b1;
      end else begin
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
         color_ff    <= color_in;
         stopped_ff  <= stopped_in;
      end
   end

endmodule

// ===== hdl/gpg_scan.sv =====
// Glyph scanner: shifts the glyph bits out one per cycle, column by column, while the
// output register is not stalled, and holds each lit pixel there. Depends on gpg_pkg.
module gpg_scan (
   input  logic                   clock,
   input  logic                   reset,
   input  gpg_pkg::scan_load_type scan_load,
   output logic                   busy,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [7:0]             out_x,
   output logic [7:0]             out_y,
   output logic [15:0]            out_color,
   output logic                   out_last
);
   import gpg_pkg::*;

   glyph_type   bits_ff, bits_in;
   logic [2:0]  row_ff, row_in;
   logic [2:0]  col_ff, col_in;
   logic [7:0]  base_x_ff, base_x_in;
   logic [7:0]  base_y_ff, base_y_in;
   logic [15:0] color_ff, color_in;
   logic        valid_ff, valid_in;
   logic [7:0]  x_ff, x_in;
   logic [7:0]  y_ff, y_in;
   logic [15:0] pcolor_ff, pcolor_in;
   logic        last_ff, last_in;
   logic        step;
   glyph_type   rest;

   always_comb begin
      step = !valid_ff || out_ready;
      rest = bits_ff >> 1;

      bits_in   = bits_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      base_x_in = base_x_ff;
      base_y_in = base_y_ff;
      color_in  = color_ff;
      valid_in  = step ? 1'b0 : valid_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      pcolor_in = pcolor_ff;
      last_in   = last_ff;

      if (scan_load.load) begin
         bits_in   = scan_load.glyph;
         row_in    = '0;
         col_in    = '0;
         base_x_in = scan_load.base_x;
         base_y_in = scan_load.base_y;
         color_in  = scan_load.color;
      end else if (step && busy) begin
         bits_in = rest;
         if (row_ff == LastRow) begin
            row_in = '0;
            col_in = col_ff + 3'd1;
         end else begin
            row_in = row_ff + 3'd1;
         end
         if (bits_ff[0]) begin
            valid_in  = 1'b1;
            x_in      = base_x_ff + {5'd0, col_ff};
            y_in      = base_y_ff + {5'd0, row_ff};
            pcolor_in = color_ff;
            last_in   = rest == '0;   // nothing lit further on
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         bits_ff  <= bits_in;
         valid_ff <= valid_in;
      end
      row_ff    <= row_in;
      col_ff    <= col_in;
      base_x_ff <= base_x_in;
      base_y_ff <= base_y_in;
      color_ff  <= color_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      pcolor_ff <= pcolor_in;
      last_ff   <= last_in;
   end

   assign busy      = bits_ff != '0;
   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_color = pcolor_ff;
   assign out_last  = last_ff;

endmodule

// ===== hdl/glyph_pixel_generator_5x7.sv =====
// 5x7 glyph pixel generator. Glyph bits are scanned one per cycle from the cycle after
// the character beat, except while the output register is stalled; each lit bit's pixel
// is then held in the output register. A character holds the input off until the last of
// its lit bits has been scanned; start, NUL, blank and ignored beats do not hold it.
// Reset: cursor and color zero, text stopped until a start beat, output register empty.
module glyph_pixel_generator_5x7 (
   input logic       clock,
   input logic       reset,
   gpg_req_if.sink   req_ch,
   gpg_rsp_if.source rsp_ch
);
   import gpg_pkg::*;

   scan_load_type scan_load;
   logic          busy;
   logic          accept;

   assign req_ch.ready = !busy;
   assign accept       = req_ch.valid && !busy;

   gpg_text u_text (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .kind       (req_ch.kind),
      .char_code  (req_ch.char_code),
      .start_x    (req_ch.start_x),
      .start_y    (req_ch.start_y),
      .text_color (req_ch.text_color),
      .scan_load  (scan_load)
   );

   gpg_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .scan_load (scan_load),
      .busy      (busy),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_x     (rsp_ch.pixel_x),
      .out_y     (rsp_ch.pixel_y),
      .out_color (rsp_ch.pixel_color),
      .out_last  (rsp_ch.last)
   );

endmodule

// ===== hdl/gpg_checker.sv =====
// Port-level checks for the glyph pixel generator, bound to the top level.
// Depends on gpg_pkg and glyph_pixel_generator_5x7.
module gpg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_kind,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_pixel_x,
   input logic [7:0]  rsp_pixel_y,
   input logic [15:0] rsp_pixel_color,
   input logic        rsp_last
);
   import gpg_pkg::*;

   // stalled beat keeps valid and payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_x) &&
      $stable(rsp_pixel_y) && $stable(rsp_pixel_color) && $stable(rsp_last))
      else $error("rsp beat changed while stalled");

   // output register is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // more pixels of this glyph pending: no new text beat may be taken
   a_no_take_mid_glyph: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("req ready while glyph still scanning");

   // a start beat never produces a pixel
   a_start_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == KindStart |=> !$rose(rsp_valid))
      else $error("pixel emitted after start beat");

endmodule

bind glyph_pixel_generator_5x7 gpg_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .req_kind        (req_ch.kind),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_pixel_x     (rsp_ch.pixel_x),
   .rsp_pixel_y     (rsp_ch.pixel_y),
   .rsp_pixel_color (rsp_ch.pixel_color),
   .rsp_last        (rsp_ch.last)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for glyph_pixel_generator_5x7: text beats in, lit pixels out.
// Depends on gpg_pkg (hdl/gpg_pkg.sv), the channel interfaces in hdl/gpg_if.sv and glyph_pixel_generator_5x7.
module tb;
   import gpg_pkg::*;

   localparam int HalfPeriod    = 4;
   localparam int ResetCycles   = 7;
   localparam int WatchdogLimit = 2000;
   localparam int DrainCycles   = 40;
   localparam int ItemTarget    = 330;
   localparam int MaxReports    = 10;
   localparam logic [7:0] UpperA = 8'h41;
   localparam logic [7:0] UpperZ = 8'h5A;

   typedef struct packed {
      logic [7:0]  x;
      logic [7:0]  y;
      logic [15:0] color;
      logic        last;
   } pixel_type;

   // Tracks the text cursor and holds the pixels still owed by the block
   class glyph_scoreboard;
      logic [7:0]  cur_x;
      logic [7:0]  cur_y;
      logic [15:0] ink;
      bit          halted;
      pixel_type   pending_px[$];
      int          mismatches;
      int          pixels_seen;
      int          chars_drawn;

      function new();
         cur_x       = '0;
         cur_y       = '0;
         ink         = '0;
         halted      = 1'b1;
         mismatches  = 0;
         pixels_seen = 0;
         chars_drawn = 0;
      endfunction

      // Column 0 in the top byte, bit 0 of each column is the top row
      function logic [39:0] letter_bitmap(int idx);
         case (idx)
            0:  return 40'h7C_12_11_12_7C;
            1:  return 40'h7F_49_49_49_36;
            2:  return 40'h3E_41_41_41_22;
            3:  return 40'h7F_41_41_22_1C;
            4:  return 40'h7F_49_49_49_41;
            5:  return 40'h7F_09_09_09_01;
            6:  return 40'h3E_41_49_49_7A;
            7:  return 40'h7F_08_08_08_7F;
            8:  return 40'h00_41_7F_41_00;
            9:  return 40'h20_40_41_3F_01;
            10: return 40'h7F_08_14_22_41;
            11: return 40'h7F_40_40_40_40;
            12: return 40'h7F_02_0C_02_7F;
            13: return 40'h7F_04_08_10_7F;
            14: return 40'h3E_41_41_41_3E;
            15: return 40'h7F_09_09_09_06;
            16: return 40'h3E_41_51_21_5E;
            17: return 40'h7F_09_19_29_46;
            18: return 40'h46_49_49_49_31;
            19: return 40'h01_01_7F_01_01;
            20: return 40'h3F_40_40_40_3F;
            21: return 40'h1F_20_40_20_1F;
            22: return 40'h3F_40_38_40_3F;
            23: return 40'h63_14_08_14_63;
            24: return 40'h07_08_70_08_07;
            25: return 40'h61_51_49_45_43;
            default: return 40'h0;
         endcase
      endfunction

      // Returns 1 when the beat changed state or drew, 0 when the block ignores it
      function bit note_item(logic kind, logic [7:0] code, logic [7:0] sx,
                             logic [7:0] sy, logic [15:0] color);
         logic [7:0]  folded;
         logic [39:0] cols;
         logic [7:0]  line;
         pixel_type   px;
         int          n_before;
         if (kind == KindStart) begin
            cur_x  = sx;
            cur_y  = sy;
            ink    = color;
            halted = 1'b0;
            return 1'b1;
         end
         if (halted)
            return 1'b0;
         if (code == CodeNul) begin
            halted = 1'b1;
            return 1'b1;
         end
         folded = code;
         if (folded >= LowerA && folded <= LowerZ)
            folded = folded - CaseOffset;
         n_before = pending_px.size();
         if (folded >= UpperA && folded <= UpperZ) begin
            cols = letter_bitmap(int'(folded - UpperA));
            for (int c = 0; c < 5; c++) begin
               line = cols[39 - 8*c -: 8];
               for (int r = 0; r < 7; r++) begin
                  if (line[r]) begin
                     px.x     = cur_x + c[7:0];
                     px.y     = cur_y + r[7:0];
                     px.color = ink;
                     px.last  = 1'b0;
                     pending_px.push_back(px);
                  end
               end
            end
            if (pending_px.size() > n_before) begin
               px = pending_px.pop_back();
               px.last = 1'b1;
               pending_px.push_back(px);
               chars_drawn++;
            end
         end
         cur_x = cur_x + Advance;
         if (cur_x > LineLimit)
            halted = 1'b1;
         return 1'b1;
      endfunction

      function void check_pixel(logic [7:0] x, logic [7:0] y, logic [15:0] color,
                                logic last);
         pixel_type want;
         pixels_seen++;
         if (pending_px.size() == 0) begin
            mismatches++;
            if (mismatches <= MaxReports)
               $display("%0t: pixel with none expected: x=%0d y=%0d color=%h last=%b",
                        $realtime, x, y, color, last);
            return;
         end
         want = pending_px.pop_front();
         if (want.x !== x || want.y !== y || want.color !== color || want.last !== last) begin
            mismatches++;
            if (mismatches <= MaxReports)
               $display("%0t: pixel %0d expected x=%0d y=%0d color=%h last=%b,",
                        $realtime, pixels_seen, want.x, want.y, want.color, want.last,
                        " got x=%0d y=%0d color=%h last=%b", x, y, color, last);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   req_gaps;
   bit   rsp_stalls;
   int   live_items;
   int   total_items;
   int   idle_cycles;

   glyph_scoreboard sb = new();

   gpg_req_if req_ch();
   gpg_rsp_if rsp_ch();

   glyph_pixel_generator_5x7 dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.kind       = KindStart;
      req_ch.char_code  = '0;
      req_ch.start_x    = '0;
      req_ch.start_y    = '0;
      req_ch.text_color = '0;
      rsp_ch.ready      = 1'b0;
   end

   always #HalfPeriod clock = ~clock;

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 15);
      if (r < 8)
         return 0;
      else if (r < 14)
         return $urandom_range(1, 3);
      else if (r < 15)
         return $urandom_range(4, 8);
      return $urandom_range(20, 40);
   endfunction

   // Character mix for a line of text: mostly letters, some blanks and odd codes
   function automatic logic [7:0] text_char();
      int r;
      r = $urandom_range(0, 31);
      if (r < 16) return 8'($urandom_range(65, 90));
      if (r < 25) return 8'($urandom_range(97, 122));
      if (r < 27) return 8'd32;
      if (r < 28) return 8'($urandom_range(33, 64));
      if (r < 29) return CodeNul;
      if (r < 30) return 8'($urandom_range(91, 96));
      if (r < 31) return 8'($urandom_range(123, 255));
      return 8'($urandom_range(0, 255));
   endfunction

   // Entered at a falling edge; leaves valid high for a back-to-back beat
   task automatic send_item(input logic kind, input logic [7:0] code, input logic [7:0] sx,
                            input logic [7:0] sy, input logic [15:0] color);
      int gap;
      gap = req_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid      = 1'b1;
      req_ch.kind       = kind;
      req_ch.char_code  = code;
      req_ch.start_x    = sx;
      req_ch.start_y    = sy;
      req_ch.text_color = color;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (sb.note_item(kind, code, sx, sy, color))
         live_items++;
      total_items++;
      @(negedge clock);
   endtask

   task automatic send_char(input logic [7:0] code);
      send_item(KindChar, code, 8'($urandom), 8'($urandom), 16'($urandom));
   endtask

   task automatic wait_drained();
      req_ch.valid = 1'b0;
      while (sb.pending_px.size() != 0) @(negedge clock);
   endtask

   task automatic random_line();
      int          r;
      logic [7:0]  sx;
      r = $urandom_range(0, 7);
      if (r < 6)
         sx = 8'($urandom_range(0, 122));
      else if (r < 7)
         sx = 8'($urandom_range(123, 255));
      else
         sx = 8'($urandom_range(0, 255));
      send_item(KindStart, 8'($urandom), sx, 8'($urandom), 16'($urandom));
      repeat ($urandom_range(1, 22)) send_char(text_char());
   endtask

   // Result side: random stalls, or ready held high for a whole stretch
   initial begin : ready_gen
      int hold;
      hold = 0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_ch.ready = 1'b0;
            hold--;
         end else begin
            rsp_ch.ready = 1'b1;
            if (rsp_stalls && $urandom_range(0, 3) == 0)
               hold = pick_gap();
         end
      end
   end

   always @(posedge clock)
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_pixel(rsp_ch.pixel_x, rsp_ch.pixel_y, rsp_ch.pixel_color, rsp_ch.last);

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("%0t: no beat moved for %0d cycles, giving up", $realtime, WatchdogLimit);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin : stimulus
      live_items  = 0;
      total_items = 0;
      req_gaps    = 1'b1;
      rsp_stalls  = 1'b1;
      repeat (ResetCycles) @(negedge clock);
      reset = 1'b0;

      // Text is stopped out of reset, so this letter must draw nothing
      send_char("A");
      send_item(KindStart, 8'hFF, 8'd0, 8'd0, 16'hFFFF);
      send_char("A");
      send_char("z");
      send_char(" ");
      send_char("!");
      send_char("@");
      send_char(8'd91);
      send_char(8'd96);
      send_char(8'd123);
      send_char(8'd255);
      send_char("M");
      send_char("W");
      send_char(CodeNul);
      send_char("Q");
      // Coordinates wrap past 255, cursor wraps to 0 and keeps going
      send_item(KindStart, 8'h00, 8'd250, 8'd252, 16'h0000);
      send_char("W");
      send_char("Z");
      // Start beyond the line limit: one character, then stop
      send_item(KindStart, 8'h5A, 8'd200, 8'd255, 16'hA5A5);
      send_char("B");
      send_char("C");
      send_item(KindStart, 8'h00, 8'd117, 8'd100, 16'h5A5A);
      send_char("a");
      send_char("Y");
      wait_drained();

      while (total_items < ItemTarget) begin
         req_gaps   = $urandom_range(0, 3) != 0;
         rsp_stalls = $urandom_range(0, 3) != 0;
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 4))
               send_item(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
                         8'($urandom), 16'($urandom));
         else
            random_line();
      end

      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      $display("Sent %0d text beats (%0d not ignored), %0d glyphs drawn, %0d pixels checked",
               total_items, live_items, sb.chars_drawn, sb.pixels_seen);
      if (sb.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== glyph_pixel_generator_5x7.f =====
hdl/gpg_pkg.sv
hdl/gpg_if.sv
hdl/gpg_text.sv
hdl/gpg_scan.sv
hdl/glyph_pixel_generator_5x7.sv
hdl/gpg_checker.sv
tb/tb.sv
